### hdl/farey_rational_approximation_top_assert.svh
// assertion macros for the rational approximation block
// expects clk and rst in the scope where the macros are used
`ifndef FAREY_RATIONAL_APPROXIMATION_TOP_ASSERT_SVH
`define FAREY_RATIONAL_APPROXIMATION_TOP_ASSERT_SVH

// same-cycle implication
`define FRA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define FRA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/fra_pkg.sv
// shared constants and types for the rational approximation block
// no dependencies
`default_nettype none

package fra_pkg;

  // default widths
  localparam int FRACTION_BITS = 32;
  localparam int DENOM_BITS    = 20;
  localparam int WHOLE_BITS    = 31;
  localparam int TOL_BITS      = 8;

  // register reset values
  localparam int MAX_DENOM_RESET = 100000;
  localparam int TOL_RESET       = 2;

  // configuration register indexes
  localparam int CFG_INDEX_BITS = 1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_MAX_DENOM = 1'b0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_TOLERANCE = 1'b1;

  // sequencer status toward the top level
  typedef struct packed {
    logic busy;
    logic result_pending;
  } seq_status_t;

endpackage

`default_nettype wire

### hdl/fra_if.sv
// channel interfaces: input sample, result, configuration write
// depends on fra_pkg
`default_nettype none

interface fra_sample_if #(
  parameter int FRACTION_BITS = fra_pkg::FRACTION_BITS
);
  logic                           valid;
  logic                           ready;
  logic                           negative;
  logic [fra_pkg::WHOLE_BITS-1:0] whole_in;
  logic [FRACTION_BITS-1:0]       fraction_in;

  modport source (output valid, negative, whole_in, fraction_in, input ready);
  modport sink   (input valid, negative, whole_in, fraction_in, output ready);
endinterface

interface fra_result_if #(
  parameter int DENOM_BITS = fra_pkg::DENOM_BITS
);
  logic                           valid;
  logic                           ready;
  logic                           negative_out;
  logic [fra_pkg::WHOLE_BITS-1:0] whole_out;
  logic [DENOM_BITS-1:0]          numerator;
  logic [DENOM_BITS-1:0]          denominator;

  modport source (output valid, negative_out, whole_out, numerator, denominator,
                  input ready);
  modport sink   (input valid, negative_out, whole_out, numerator, denominator,
                  output ready);
endinterface

interface fra_cfg_if #(
  parameter int DENOM_BITS = fra_pkg::DENOM_BITS
);
  logic                               valid;
  logic                               ready;
  logic [fra_pkg::CFG_INDEX_BITS-1:0] index;
  logic [DENOM_BITS-1:0]              data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

### hdl/fra_mul.sv
// shared multiplier: x * q and tolerance * q, both registered
// depends on fra_pkg
`default_nettype none

module fra_mul #(
  parameter int FRACTION_BITS = fra_pkg::FRACTION_BITS,
  parameter int DENOM_BITS    = fra_pkg::DENOM_BITS
) (
  input  wire logic                                  clk,
  input  wire logic                                  en,
  input  wire logic [FRACTION_BITS-1:0]              x,
  input  wire logic [DENOM_BITS:0]                   q,
  input  wire logic [fra_pkg::TOL_BITS-1:0]          tol,
  output logic      [FRACTION_BITS+DENOM_BITS:0]     xq,
  output logic      [DENOM_BITS+fra_pkg::TOL_BITS:0] tq
);

  localparam int PW = FRACTION_BITS + DENOM_BITS + 1;
  localparam int TW = DENOM_BITS + fra_pkg::TOL_BITS + 1;

  // products captured when the sequencer asks
  always_ff @(posedge clk) begin
    if (en) begin
      xq <= PW'(x) * PW'(q);
      tq <= TW'(tol) * TW'(q);
    end
  end

endmodule

`default_nettype wire

### hdl/fra_seq.sv
// mediant walk sequencer: bounds, compare, result register
// depends on fra_pkg and fra_mul
`default_nettype none

module fra_seq #(
  parameter int FRACTION_BITS = fra_pkg::FRACTION_BITS,
  parameter int DENOM_BITS    = fra_pkg::DENOM_BITS
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic [DENOM_BITS-1:0]          max_denominator,
  input  wire logic [fra_pkg::TOL_BITS-1:0]   tolerance,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic                           in_negative,
  input  wire logic [fra_pkg::WHOLE_BITS-1:0] in_whole,
  input  wire logic [FRACTION_BITS-1:0]       in_fraction,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic                                out_negative,
  output logic [fra_pkg::WHOLE_BITS-1:0]      out_whole,
  output logic [DENOM_BITS-1:0]               out_num,
  output logic [DENOM_BITS-1:0]               out_den,
  output fra_pkg::seq_status_t                status
);

  localparam int BW = DENOM_BITS + 1;
  localparam int PW = FRACTION_BITS + DENOM_BITS + 1;
  localparam int TW = DENOM_BITS + fra_pkg::TOL_BITS + 1;

  typedef enum logic [1:0] {S_IDLE, S_MUL, S_CMP, S_FIN} state_t;

  state_t                          state;
  logic [BW-1:0]                   low_num, low_den, high_num, high_den;
  logic [BW-1:0]                   med_num, med_den;
  logic                            use_high;
  logic [FRACTION_BITS-1:0]        x;
  logic                            negative;
  logic [fra_pkg::WHOLE_BITS-1:0]  whole;
  logic [PW-1:0]                   xq;
  logic [TW-1:0]                   tq;

  logic [BW-1:0] lim;
  logic [PW-1:0] pq, diff;
  logic          above, close, med_fits;
  logic [BW-1:0] low_num_next, low_den_next, high_num_next, high_den_next;
  logic          more;
  logic          in_take, out_free;

  // shared multiplier
  fra_mul #(
    .FRACTION_BITS(FRACTION_BITS),
    .DENOM_BITS   (DENOM_BITS)
  ) u_mul (
    .clk(clk),
    .en (state == S_MUL),
    .x  (x),
    .q  (med_den),
    .tol(tolerance),
    .xq (xq),
    .tq (tq)
  );

  // distance of the mediant from x and the side x falls on
  always_comb begin
    lim      = BW'(max_denominator);
    pq       = {med_num, {FRACTION_BITS{1'b0}}};
    above    = xq > pq;
    diff     = above ? (xq - pq) : (pq - xq);
    close    = diff <= PW'(tq);
    med_fits = med_den <= lim;
  end

  // bounds after a step that did not match
  always_comb begin
    low_num_next  = above ? med_num : low_num;
    low_den_next  = above ? med_den : low_den;
    high_num_next = above ? high_num : med_num;
    high_den_next = above ? high_den : med_den;
    more          = (low_den_next <= lim) && (high_den_next <= lim);
  end

  assign in_ready = (state == S_IDLE) && !rst;
  assign in_take  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  assign status.busy           = (state != S_IDLE);
  assign status.result_pending = out_valid;

  // sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      // a taken result frees the register unless a new one loads now
      if (out_valid && out_ready && state != S_FIN) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_take) begin
            x        <= in_fraction;
            negative <= in_negative;
            whole    <= in_whole;
            low_num  <= BW'(0);
            low_den  <= BW'(1);
            high_num <= BW'(1);
            high_den <= BW'(1);
            med_num  <= BW'(1);
            med_den  <= BW'(2);
            use_high <= (max_denominator == '0);
            state    <= (max_denominator == '0) ? S_FIN : S_MUL;
          end
        end
        S_MUL: begin
          state <= S_CMP;
        end
        S_CMP: begin
          if (close) begin
            if (med_fits) begin
              low_num  <= med_num;
              low_den  <= med_den;
              use_high <= 1'b0;
            end else begin
              use_high <= high_den > low_den;
            end
            state <= S_FIN;
          end else begin
            low_num  <= low_num_next;
            low_den  <= low_den_next;
            high_num <= high_num_next;
            high_den <= high_den_next;
            med_num  <= low_num_next + high_num_next;
            med_den  <= low_den_next + high_den_next;
            use_high <= low_den_next > lim;
            state    <= more ? S_MUL : S_FIN;
          end
        end
        S_FIN: begin
          if (out_free) begin
            out_valid    <= 1'b1;
            out_negative <= negative;
            out_whole    <= whole;
            out_num      <= use_high ? high_num[DENOM_BITS-1:0] : low_num[DENOM_BITS-1:0];
            out_den      <= use_high ? high_den[DENOM_BITS-1:0] : low_den[DENOM_BITS-1:0];
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### hdl/farey_rational_approximation_top.sv
// Best rational approximation p/q of a fixed-point fraction by a Stern-Brocot
// walk from 0/1 and 1/1. One sample is worked on at a time: each mediant step
// passes through the shared multiplier and then the compare and bound update,
// the result register loads in the finish state that follows the last step once
// it is free, and the input is ready again in the cycle after that load.
// The step count grows toward max_denominator for fractions close to zero or
// one; a zero limit takes no step. The finished result sits in an output
// register, so a new sample is taken while it waits; a second finished result
// waits in the sequencer and holds the input off until the register frees.
// Sign and integer part ride along.
// Depends on fra_pkg, fra_if, fra_mul, fra_seq and the assertion header.
`default_nettype none

`include "farey_rational_approximation_top_assert.svh"

module farey_rational_approximation_top #(
  parameter int FRACTION_BITS = fra_pkg::FRACTION_BITS,
  parameter int DENOM_BITS    = fra_pkg::DENOM_BITS
) (
  input wire logic clk,
  input wire logic rst,
  fra_sample_if.sink   sample,
  fra_result_if.source result,
  fra_cfg_if.sink      cfg
);

  logic [DENOM_BITS-1:0]        max_denominator;
  logic [fra_pkg::TOL_BITS-1:0] tolerance;
  fra_pkg::seq_status_t         status;

  // configuration registers, ready whenever out of reset
  assign cfg.ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_denominator <= DENOM_BITS'(fra_pkg::MAX_DENOM_RESET);
      tolerance       <= fra_pkg::TOL_BITS'(fra_pkg::TOL_RESET);
    end else if (cfg.valid) begin
      unique case (cfg.index)
        fra_pkg::REG_MAX_DENOM: max_denominator <= cfg.data;
        fra_pkg::REG_TOLERANCE: tolerance <= cfg.data[fra_pkg::TOL_BITS-1:0];
        default: ;
      endcase
    end
  end

  // mediant walk
  fra_seq #(
    .FRACTION_BITS(FRACTION_BITS),
    .DENOM_BITS   (DENOM_BITS)
  ) u_seq (
    .clk            (clk),
    .rst            (rst),
    .max_denominator(max_denominator),
    .tolerance      (tolerance),
    .in_valid       (sample.valid),
    .in_ready       (sample.ready),
    .in_negative    (sample.negative),
    .in_whole       (sample.whole_in),
    .in_fraction    (sample.fraction_in),
    .out_valid      (result.valid),
    .out_ready      (result.ready),
    .out_negative   (result.negative_out),
    .out_whole      (result.whole_out),
    .out_num        (result.numerator),
    .out_den        (result.denominator),
    .status         (status)
  );

  // checks on the walk and the result register
  `FRA_ASSERT_NEXT(a_take_busy, sample.valid && sample.ready, status.busy, "no walk after beat")
  `FRA_ASSERT_NOW(a_den_nonzero, status.result_pending, result.denominator != '0, "zero den")
  `FRA_ASSERT_NOW(a_num_le_den, status.result_pending, result.numerator <= result.denominator, "above one")

endmodule

`default_nettype wire
